// ----- hw/rtl/rfkpc_pkg.sv -----
// rfkpc_pkg: shared types and constants for the remote key press classifier
// holds phase and event codes, register map, reset values and the config bundle
// no dependencies
package rfkpc_pkg;

    localparam int KeyW   = 6;
    localparam int TickW  = 8;
    localparam int ResW   = 3;
    localparam int AddrW  = 5;
    localparam int DataW  = 32;

    localparam logic [KeyW-1:0] KeyMask = 6'h3F;

    // register map, index = paddr[4:2]
    localparam logic [2:0] RegGapLimit   = 3'd0;
    localparam logic [2:0] RegLongTime   = 3'd1;
    localparam logic [2:0] RegRepeatTime = 3'd2;
    localparam logic [2:0] RegDoubleMin  = 3'd3;
    localparam logic [2:0] RegDoubleMax  = 3'd4;
    localparam logic [2:0] RegIgnoreTime = 3'd5;

    localparam logic [TickW-1:0] GapLimitRst   = 8'd12;
    localparam logic [TickW-1:0] LongTimeRst   = 8'd75;
    localparam logic [TickW-1:0] RepeatTimeRst = 8'd90;
    localparam logic [TickW-1:0] DoubleMinRst  = 8'd5;
    localparam logic [TickW-1:0] DoubleMaxRst  = 8'd11;
    localparam logic [TickW-1:0] IgnoreTimeRst = 8'd22;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_PRESS  = 3'd1,
        PH_LONG   = 3'd2,
        PH_WINDOW = 3'd3,
        PH_IGNORE = 3'd4
    } phase_t;

    typedef enum logic [ResW-1:0] {
        EV_SHORT   = 3'd0,
        EV_DOUBLE  = 3'd1,
        EV_LONG    = 3'd2,
        EV_CONT    = 3'd3,
        EV_RELEASE = 3'd4
    } event_t;

    typedef struct packed {
        logic [TickW-1:0] gap_limit;
        logic [TickW-1:0] long_time;
        logic [TickW-1:0] repeat_time;
        logic [TickW-1:0] double_min;
        logic [TickW-1:0] double_max;
        logic [TickW-1:0] ignore_time;
    } cfg_t;

    typedef struct packed {
        logic            valid;
        event_t          code;
        logic [KeyW-1:0] key;
    } result_t;

endpackage

// ----- hw/rtl/rfkpc_core.sv -----
// rfkpc_core: press state and single-pass classification of one beat
// depends on rfkpc_pkg
module rfkpc_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      fire,
    input  logic                      kind,
    input  logic [rfkpc_pkg::KeyW-1:0] key_code,
    input  logic                      addr_match,
    input  rfkpc_pkg::cfg_t           cfg,
    output rfkpc_pkg::result_t        res
);
    import rfkpc_pkg::*;

    phase_t           phase_reg,  phase_next;
    logic [KeyW-1:0]  held_reg,   held_next;
    logic [KeyW-1:0]  first_reg,  first_next;
    logic [TickW-1:0] gap_reg,    gap_next;
    logic [TickW-1:0] press_reg,  press_next;
    logic [TickW-1:0] window_reg, window_next;

    logic [TickW:0]   gap_inc;
    logic [TickW:0]   win_inc;
    logic [TickW:0]   press_sum;
    logic [TickW-1:0] press_acc;
    logic             end_press;

    assign gap_inc   = {1'b0, gap_reg} + 9'd1;
    assign win_inc   = {1'b0, window_reg} + 9'd1;
    assign press_sum = {1'b0, press_reg} + {1'b0, gap_reg};
    assign press_acc = press_sum[TickW] ? {TickW{1'b1}} : press_sum[TickW-1:0];

    always_comb
    begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        first_next  = first_reg;
        gap_next    = gap_reg;
        press_next  = press_reg;
        window_next = window_reg;
        end_press   = 1'b0;
        res.valid   = 1'b0;
        res.code    = EV_SHORT;
        res.key     = '0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (kind && addr_match)
                begin
                    phase_next = PH_PRESS;
                    held_next  = key_code;
                    gap_next   = '0;
                    press_next = '0;
                end
            end
            PH_PRESS, PH_LONG:
            begin
                if (!kind)
                begin
                    if (gap_inc <= {1'b0, cfg.gap_limit})
                        gap_next = gap_inc[TickW-1:0];
                    else
                        end_press = 1'b1;
                end
                else if (gap_reg <= cfg.gap_limit)
                begin
                    if (addr_match)
                    begin
                        // frame inside the gap extends the press
                        press_next = press_acc;
                        gap_next   = '0;
                        held_next  = key_code;
                        if (phase_reg == PH_PRESS)
                        begin
                            if (press_acc >= cfg.long_time)
                            begin
                                phase_next = PH_LONG;
                                res.valid  = 1'b1;
                                res.code   = EV_LONG;
                                res.key    = key_code;
                            end
                        end
                        else if (press_acc >= cfg.repeat_time)
                        begin
                            press_next = cfg.long_time;
                            res.valid  = 1'b1;
                            res.code   = EV_CONT;
                            res.key    = key_code;
                        end
                    end
                end
                else
                begin
                    end_press = 1'b1;
                end

                if (end_press)
                begin
                    held_next   = '0;
                    gap_next    = '0;
                    press_next  = '0;
                    window_next = '0;
                    if (phase_reg == PH_PRESS)
                    begin
                        first_next = held_reg;
                        phase_next = PH_WINDOW;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        res.valid  = 1'b1;
                        res.code   = EV_RELEASE;
                        res.key    = held_reg;
                    end
                end
            end
            PH_WINDOW:
            begin
                if (!kind)
                begin
                    if (win_inc > {1'b0, cfg.double_max})
                    begin
                        phase_next  = PH_IDLE;
                        held_next   = '0;
                        gap_next    = '0;
                        press_next  = '0;
                        window_next = '0;
                        res.valid   = 1'b1;
                        res.code    = EV_SHORT;
                        res.key     = first_reg;
                    end
                    else
                    begin
                        window_next = win_inc[TickW-1:0];
                    end
                end
                else if (window_reg > cfg.double_min)
                begin
                    held_next   = '0;
                    gap_next    = '0;
                    press_next  = '0;
                    window_next = '0;
                    res.valid   = 1'b1;
                    res.key     = first_reg;
                    if (addr_match && key_code == first_reg && window_reg < cfg.double_max)
                    begin
                        phase_next = (cfg.ignore_time != '0) ? PH_IGNORE : PH_IDLE;
                        res.code   = EV_DOUBLE;
                    end
                    else
                    begin
                        res.code = EV_SHORT;
                        if (addr_match)
                        begin
                            // the frame opens a new press
                            phase_next = PH_PRESS;
                            held_next  = key_code;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
            end
            PH_IGNORE:
            begin
                if (!kind)
                begin
                    if (win_inc >= {1'b0, cfg.ignore_time})
                    begin
                        phase_next  = PH_IDLE;
                        held_next   = '0;
                        gap_next    = '0;
                        press_next  = '0;
                        window_next = '0;
                    end
                    else
                    begin
                        window_next = win_inc[TickW-1:0];
                    end
                end
            end
            default:
            begin
                phase_next  = PH_IDLE;
                held_next   = '0;
                gap_next    = '0;
                press_next  = '0;
                window_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            held_reg   <= '0;
            first_reg  <= '0;
            gap_reg    <= '0;
            press_reg  <= '0;
            window_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            first_reg  <= first_next;
            gap_reg    <= gap_next;
            press_reg  <= press_next;
            window_reg <= window_next;
        end
    end

    // idle always carries cleared counters
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (gap_reg == '0 && press_reg == '0 && window_reg == '0))
        else $error("idle with live counters");

    // the window never carries press timing
    a_window_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_WINDOW) |-> (gap_reg == '0 && press_reg == '0))
        else $error("window with press timing");

    // state only moves on a processed beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(phase_reg) && $stable(window_reg))
        else $error("state moved without a beat");

endmodule

// ----- hw/rtl/rf_key_press_classifier.sv -----
// rf_key_press_classifier: top level, apb register file, input and result registers
// depends on rfkpc_pkg and rfkpc_core
// an input beat is held in the input register, and its result in the result register
// throughput: one beat per cycle while out_ready is high; the core does one beat in one pass
// a beat that makes no event is consumed with no result beat
// reset: rst_n clears phase, counters and both valid flags; registers return to defaults
module rf_key_press_classifier (
    input  logic                        clk,
    input  logic                        rst_n,
    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        kind,
    input  logic [rfkpc_pkg::KeyW-1:0]  key_code,
    input  logic                        addr_match,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [rfkpc_pkg::ResW-1:0]  event_res,
    output logic [rfkpc_pkg::KeyW-1:0]  event_key,
    // apb configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rfkpc_pkg::AddrW-1:0] paddr,
    input  logic [rfkpc_pkg::DataW-1:0] pwdata,
    output logic [rfkpc_pkg::DataW-1:0] prdata,
    output logic                        pready
);
    import rfkpc_pkg::*;

    cfg_t             cfg_reg;
    logic             wr_en;
    logic [2:0]       reg_idx;

    logic             in_valid_reg;
    logic             kind_reg;
    logic [KeyW-1:0]  key_reg;
    logic             match_reg;

    logic             out_valid_reg;
    logic [ResW-1:0]  res_reg;
    logic [KeyW-1:0]  out_key_reg;

    logic             fire;
    result_t          core_res;

    // register file: write on the access phase, reads are combinational
    assign pready  = 1'b1;
    assign reg_idx = paddr[AddrW-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gap_limit   <= GapLimitRst;
            cfg_reg.long_time   <= LongTimeRst;
            cfg_reg.repeat_time <= RepeatTimeRst;
            cfg_reg.double_min  <= DoubleMinRst;
            cfg_reg.double_max  <= DoubleMaxRst;
            cfg_reg.ignore_time <= IgnoreTimeRst;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                RegGapLimit:   cfg_reg.gap_limit   <= pwdata[TickW-1:0];
                RegLongTime:   cfg_reg.long_time   <= pwdata[TickW-1:0];
                RegRepeatTime: cfg_reg.repeat_time <= pwdata[TickW-1:0];
                RegDoubleMin:  cfg_reg.double_min  <= pwdata[TickW-1:0];
                RegDoubleMax:  cfg_reg.double_max  <= pwdata[TickW-1:0];
                RegIgnoreTime: cfg_reg.ignore_time <= pwdata[TickW-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            RegGapLimit:   prdata[TickW-1:0] = cfg_reg.gap_limit;
            RegLongTime:   prdata[TickW-1:0] = cfg_reg.long_time;
            RegRepeatTime: prdata[TickW-1:0] = cfg_reg.repeat_time;
            RegDoubleMin:  prdata[TickW-1:0] = cfg_reg.double_min;
            RegDoubleMax:  prdata[TickW-1:0] = cfg_reg.double_max;
            RegIgnoreTime: prdata[TickW-1:0] = cfg_reg.ignore_time;
            default:       prdata = '0;
        endcase
    end

    // the held beat is processed whenever the result register can take a new value;
    // a beat with no event still waits for that slot so results stay in order
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg  <= kind;
            key_reg   <= key_code;
            match_reg <= addr_match;
        end
    end

    rfkpc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .kind       (kind_reg),
        .key_code   (key_reg),
        .addr_match (match_reg),
        .cfg        (cfg_reg),
        .res        (core_res)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= core_res.valid;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && core_res.valid)
        begin
            res_reg     <= core_res.code;
            out_key_reg <= core_res.key;
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = res_reg;
    assign event_key = out_key_reg;

    // an accepted beat is always captured
    a_capture: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> in_valid_reg)
        else $error("accepted beat lost");

    // a pending result is never overwritten by processing
    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

    // a new result only appears after a processed beat
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(fire))
        else $error("result without a beat");

    // a stalled result keeps its value
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(res_reg) && $stable(out_key_reg))
        else $error("stalled result changed");

endmodule

// ----- verif/testbench.sv -----
// testbench for rf_key_press_classifier: random and directed frame/tick beats,
// an in-bench press classifier that predicts each event, an event scoreboard
// depends on rfkpc_pkg and the rf_key_press_classifier rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rfkpc_pkg::*;

    localparam int IdlePct      = 28;     // percent of cycles a side holds off
    localparam int StallLimit   = 1000;   // cycles with no beat anywhere before giving up
    localparam int SettleCycles = 6;      // input and result register pipe plus margin, before register writes
    localparam int MaxStep      = 20;     // longest tick run between frames of one press

    localparam logic KindTick  = 1'b0;
    localparam logic KindFrame = 1'b1;

    typedef struct packed {
        logic            is_frame;
        logic [KeyW-1:0] code;
        logic            hit;
    } beat_t;

    typedef struct packed {
        event_t          res;
        logic [KeyW-1:0] key;
    } press_event_t;

    // dut ports, all inputs known from time zero
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic                kind       = KindTick;
    logic [KeyW-1:0]     key_code   = '0;
    logic                addr_match = 1'b0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [ResW-1:0]     event_res;
    logic [KeyW-1:0]     event_key;
    logic                psel       = 1'b0;
    logic                penable    = 1'b0;
    logic                pwrite     = 1'b0;
    logic [AddrW-1:0]    paddr      = '0;
    logic [DataW-1:0]    pwdata     = '0;
    logic [DataW-1:0]    prdata;
    logic                pready;

    // stimulus and scoreboard storage
    beat_t               pending_beats [$];
    press_event_t        expected_events [$];
    beat_t               next_beat;
    press_event_t        due;
    int                  queued_beats;
    int                  frames_in;
    int                  beats_in;
    int                  settings_used;
    int                  mismatches;
    int                  quiet_cycles;
    int                  event_tally [0:4];
    bit                  steady;          // set while neither side may idle

    // predictor copy of the register file and of the press state
    logic [TickW-1:0]    setting [0:5];
    phase_t              ph;
    logic [KeyW-1:0]     held_code;
    logic [KeyW-1:0]     first_code;
    logic [TickW-1:0]    gap_cnt;
    logic [TickW-1:0]    press_cnt;
    logic [TickW-1:0]    win_cnt;

    rf_key_press_classifier dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .key_code   (key_code),
        .addr_match (addr_match),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .event_res  (event_res),
        .event_key  (event_key),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // press classifier: same decisions as the block, one call per input beat
    // ---------------------------------------------------------------------

    task automatic clear_press();
        ph        = PH_IDLE;
        held_code = '0;
        gap_cnt   = '0;
        press_cnt = '0;
        win_cnt   = '0;
    endtask

    task automatic open_press(input logic [KeyW-1:0] k);
        ph        = PH_PRESS;
        held_code = k;
        gap_cnt   = '0;
        press_cnt = '0;
    endtask

    task automatic post_event(input event_t res, input logic [KeyW-1:0] k);
        press_event_t ev;
        ev.res = res;
        ev.key = k;
        expected_events.push_back(ev);
    endtask

    task automatic classify(input logic is_frame, input logic [KeyW-1:0] k, input logic hit);
        int              sum;
        logic [KeyW-1:0] ended;
        case (ph)
            PH_IDLE:
            begin
                if (is_frame && hit)
                    open_press(k);
            end
            PH_PRESS, PH_LONG:
            begin
                if (!is_frame && int'(gap_cnt) + 1 <= int'(setting[RegGapLimit]))
                begin
                    gap_cnt = gap_cnt + 1'b1;
                end
                else if (is_frame && gap_cnt <= setting[RegGapLimit])
                begin
                    // frames from another remote leave the press alone
                    if (hit)
                    begin
                        sum       = int'(press_cnt) + int'(gap_cnt);
                        press_cnt = (sum > 255) ? 8'd255 : TickW'(sum);
                        gap_cnt   = '0;
                        held_code = k;
                        if (ph == PH_PRESS)
                        begin
                            if (press_cnt >= setting[RegLongTime])
                            begin
                                ph = PH_LONG;
                                post_event(EV_LONG, held_code);
                            end
                        end
                        else if (press_cnt >= setting[RegRepeatTime])
                        begin
                            press_cnt = setting[RegLongTime];
                            post_event(EV_CONT, held_code);
                        end
                    end
                end
                else if (ph == PH_PRESS)
                begin
                    // gap ran out on a short press: wait for a second press
                    first_code = held_code;
                    clear_press();
                    ph = PH_WINDOW;
                end
                else
                begin
                    ended = held_code;
                    clear_press();
                    post_event(EV_RELEASE, ended);
                end
            end
            PH_WINDOW:
            begin
                if (!is_frame)
                begin
                    if (int'(win_cnt) + 1 > int'(setting[RegDoubleMax]))
                    begin
                        clear_press();
                        post_event(EV_SHORT, first_code);
                    end
                    else
                    begin
                        win_cnt = win_cnt + 1'b1;
                    end
                end
                else if (win_cnt > setting[RegDoubleMin])
                begin
                    if (hit && k == first_code && win_cnt < setting[RegDoubleMax])
                    begin
                        clear_press();
                        if (setting[RegIgnoreTime] != '0)
                            ph = PH_IGNORE;
                        post_event(EV_DOUBLE, first_code);
                    end
                    else
                    begin
                        clear_press();
                        if (hit)
                            open_press(k);
                        post_event(EV_SHORT, first_code);
                    end
                end
            end
            PH_IGNORE:
            begin
                if (!is_frame)
                begin
                    if (int'(win_cnt) + 1 >= int'(setting[RegIgnoreTime]))
                        clear_press();
                    else
                        win_cnt = win_cnt + 1'b1;
                end
            end
            default:
            begin
                clear_press();
            end
        endcase
    endtask

    // ---------------------------------------------------------------------
    // input driver: offers queued beats, predicts on each accepted beat
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                classify(kind, key_code, addr_match);
                beats_in++;
                if (kind == KindFrame)
                    frames_in++;
            end
            // load a new beat only once the held one is gone
            if (!in_valid || in_ready)
            begin
                if (pending_beats.size() != 0 && (steady || $urandom_range(0, 99) >= IdlePct))
                begin
                    next_beat  = pending_beats.pop_front();
                    in_valid   <= 1'b1;
                    kind       <= next_beat.is_frame;
                    key_code   <= next_beat.code;
                    addr_match <= next_beat.hit;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // event monitor: random back-pressure, each event beat against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_events.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: event beat with none predicted, expected nothing, %s",
                             $time, $sformatf("got res %0d key %0d", event_res, event_key));
                end
                else
                begin
                    due = expected_events.pop_front();
                    event_tally[due.res]++;
                    if (event_res !== due.res)
                    begin
                        mismatches++;
                        $display("%0t: event_res expected %0d got %0d", $time, due.res, event_res);
                    end
                    if (event_key !== due.key)
                    begin
                        mismatches++;
                        $display("%0t: event_key expected %0d got %0d", $time, due.key, event_key);
                    end
                end
            end
            out_ready <= steady || ($urandom_range(0, 99) >= IdlePct);
        end
    end

    // ---------------------------------------------------------------------
    // watchdog: any beat on any port restarts the count
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= StallLimit)
        begin
            $display("%0t: no beat for %0d cycles, %0d events still predicted",
                     $time, StallLimit, expected_events.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------
    // register port
    // ---------------------------------------------------------------------

    // setup cycle then access cycle; read data taken at the completing edge
    task automatic apb_cycle(input logic wr, input logic [2:0] idx, input logic [TickW-1:0] wdata,
                             output logic [DataW-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= AddrW'({idx, 2'b00});
        pwdata  <= DataW'(wdata);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input logic [2:0] idx);
        logic [DataW-1:0] rd;
        apb_cycle(1'b0, idx, '0, rd);
        if (rd !== DataW'(setting[idx]))
        begin
            mismatches++;
            $display("%0t: register %0d read expected %0h got %0h", $time, idx, setting[idx], rd);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [TickW-1:0] val);
        logic [DataW-1:0] unused;
        apb_cycle(1'b1, idx, val, unused);
        setting[idx] = val;
        check_reg(idx);
    endtask

    task automatic apply_settings(input logic [TickW-1:0] gap, input logic [TickW-1:0] long_t,
                                  input logic [TickW-1:0] rep, input logic [TickW-1:0] dmin,
                                  input logic [TickW-1:0] dmax, input logic [TickW-1:0] ign);
        write_reg(RegGapLimit, gap);
        write_reg(RegLongTime, long_t);
        write_reg(RegRepeatTime, rep);
        write_reg(RegDoubleMin, dmin);
        write_reg(RegDoubleMax, dmax);
        write_reg(RegIgnoreTime, ign);
        settings_used++;
        // leave the clock edge before new beats are queued
        @(negedge clk);
    endtask

    // small random register set for a run with many gestures
    task automatic apply_small_settings();
        apply_settings(TickW'($urandom_range(1, 8)), TickW'($urandom_range(1, 40)),
                       TickW'($urandom_range(1, 50)), TickW'($urandom_range(0, 6)),
                       TickW'($urandom_range(1, 12)), TickW'($urandom_range(0, 15)));
    endtask

    // wait for every beat to go in and every event to come out, then let the pipe settle
    task automatic drain();
        do
            @(negedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_events.size() != 0);
        repeat (SettleCycles)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // beat sequences
    // ---------------------------------------------------------------------

    function automatic int at_most(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    task automatic add_beat(input logic is_frame, input logic [KeyW-1:0] k, input logic hit);
        beat_t b;
        b.is_frame = is_frame;
        b.code     = k;
        b.hit      = hit;
        pending_beats.push_back(b);
        queued_beats++;
    endtask

    // key and address bits of a tick are don't-care, so they get noise
    task automatic add_ticks(input int n);
        repeat (n)
            add_beat(KindTick, KeyW'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
    endtask

    // frames of one press until about press_goal ticks have been added up
    task automatic hold_key(input logic [KeyW-1:0] k, input int press_goal);
        int held;
        int step;
        held = 0;
        add_beat(KindFrame, k, 1'b1);
        while (held < press_goal)
        begin
            step = $urandom_range(1, at_most(int'(setting[RegGapLimit]), MaxStep));
            add_ticks(step);
            // stray frame from another remote
            if ($urandom_range(0, 9) == 0)
                add_beat(KindFrame, KeyW'($urandom_range(0, 63)), 1'b0);
            // key changes in mid press
            if ($urandom_range(0, 9) == 0)
                k = KeyW'($urandom_range(0, 63));
            add_beat(KindFrame, k, 1'b1);
            held += step;
        end
    endtask

    task automatic let_key_go();
        add_ticks(int'(setting[RegGapLimit]) + 1);
    endtask

    task automatic add_gesture();
        logic [KeyW-1:0] k;
        int              pick;
        int              lo;
        int              hi;
        int              short_goal;
        k          = KeyW'($urandom_range(0, 63));
        pick       = $urandom_range(0, 99);
        short_goal = $urandom_range(0, at_most(int'(setting[RegLongTime]) - 1, 10));
        if (pick < 30)
        begin
            // short press, then a random wait that may or may not close the window
            hold_key(k, short_goal);
            let_key_go();
            add_ticks($urandom_range(0, int'(setting[RegDoubleMax]) + 1));
        end
        else if (pick < 55)
        begin
            // double click aimed inside the window, then beats through the lockout
            hold_key(k, short_goal);
            let_key_go();
            lo = int'(setting[RegDoubleMin]) + 1;
            hi = int'(setting[RegDoubleMax]) - 1;
            if (lo > hi)
            begin
                lo = 0;
                hi = int'(setting[RegDoubleMax]);
            end
            add_ticks($urandom_range(lo, hi));
            add_beat(KindFrame, k, 1'b1);
            repeat (at_most(int'(setting[RegIgnoreTime]) + 2, 30))
                add_beat(1'($urandom_range(0, 1)), k, 1'b1);
        end
        else if (pick < 80)
        begin
            // long press with some repeats
            hold_key(k, int'(setting[RegLongTime]) + $urandom_range(0, 40));
            let_key_go();
        end
        else
        begin
            // noise
            repeat ($urandom_range(1, 6))
                add_beat(1'($urandom_range(0, 1)), KeyW'($urandom_range(0, 63)),
                         1'($urandom_range(0, 1)));
        end
    endtask

    task automatic random_run(input int budget);
        int first;
        first = queued_beats;
        while (queued_beats - first < budget)
            add_gesture();
    endtask

    // ---------------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------------
    initial
    begin
        // mirror of the reset state
        setting[RegGapLimit]   = GapLimitRst;
        setting[RegLongTime]   = LongTimeRst;
        setting[RegRepeatTime] = RepeatTimeRst;
        setting[RegDoubleMin]  = DoubleMinRst;
        setting[RegDoubleMax]  = DoubleMaxRst;
        setting[RegIgnoreTime] = IgnoreTimeRst;
        first_code = '0;
        clear_press();
        foreach (event_tally[i])
            event_tally[i] = 0;

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;

        // registers come out of reset at their defaults
        for (int r = RegGapLimit; r <= RegIgnoreTime; r++)
            check_reg(3'(r));

        // directed part on a tight setting so every event shows in a few beats
        apply_settings(8'd2, 8'd2, 8'd3, 8'd1, 8'd4, 8'd2);
        // other remote while idle, a press that goes long, repeats once, is let go
        add_beat(KindFrame, KeyMask, 1'b0);
        add_beat(KindFrame, KeyMask, 1'b1);
        add_ticks(2);
        add_beat(KindFrame, KeyMask, 1'b1);
        add_ticks(2);
        add_beat(KindFrame, KeyMask, 1'b1);
        add_ticks(3);
        // short press, a frame too early in the window, a double click, frames locked out
        add_beat(KindFrame, '0, 1'b1);
        add_ticks(3);
        add_beat(KindFrame, '0, 1'b1);
        add_ticks(2);
        add_beat(KindFrame, '0, 1'b1);
        add_beat(KindFrame, KeyW'(21), 1'b0);
        add_ticks(2);
        // a press left hanging two ticks in, for the lowered gap limit below
        add_beat(KindFrame, KeyW'(42), 1'b1);
        add_ticks(2);
        drain();

        // smallest values: gap limit below the hanging gap, no lockout, no idling
        apply_settings(8'd1, 8'd1, 8'd1, 8'd0, 8'd1, 8'd0);
        steady = 1'b1;
        add_beat(KindFrame, KeyW'(42), 1'b1);
        random_run(40);
        drain();
        steady = 1'b0;

        // back to the reset values
        apply_settings(GapLimitRst, LongTimeRst, RepeatTimeRst, DoubleMinRst, DoubleMaxRst,
                       IgnoreTimeRst);
        random_run(50);
        drain();

        // two random settings kept small enough for many gestures
        repeat (2)
        begin
            apply_small_settings();
            random_run(30);
            drain();
        end

        // largest values: one press held until the press time saturates, left hanging
        apply_settings(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
        hold_key(KeyW'($urandom_range(0, 63)), 255 + int'($urandom_range(0, 10)));
        add_ticks(10);
        drain();

        // lowered gap limit ends the long press on the first beat
        apply_small_settings();
        add_beat(KindFrame, KeyW'($urandom_range(0, 63)), 1'b1);
        random_run(20);
        drain();

        $display("%0d input beats (%0d frames) over %0d register settings", beats_in, frames_in,
                 settings_used);
        $display("events: short %0d, double %0d, long %0d, continue %0d, release %0d",
                 event_tally[EV_SHORT], event_tally[EV_DOUBLE], event_tally[EV_LONG],
                 event_tally[EV_CONT], event_tally[EV_RELEASE]);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
